/* hdl/csd_pkg.sv */
// ----------------------------------------------------------------------------
// csd_pkg
// Types and codes shared by the command stream decoder and its parts.
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OFFSET_W = 12;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned MASK_W   = 16;
    localparam int unsigned CLASS_W  = 10;
    localparam int unsigned CMASK_W  = 6;
    localparam int unsigned GMODE_W  = 2;
    localparam int unsigned GCOUNT_W = 14;
    localparam int unsigned SUBOP_W  = 4;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned OPCODE_W = 4;
    localparam int unsigned MIDX_W   = $clog2(MASK_W);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_MASKED = 3'd1,
        PH_INCR   = 3'd2,
        PH_FIXED  = 3'd3,
        PH_GBASE  = 3'd4
    } t_phase;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET_CLASS = 4'd0,
        OP_INCR      = 4'd1,
        OP_NONINCR   = 4'd2,
        OP_MASK      = 4'd3,
        OP_IMM       = 4'd4,
        OP_RESTART   = 4'd5,
        OP_GATHER    = 4'd6,
        OP_EXTEND    = 4'd14,
        OP_DONE      = 4'd15
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        EV_WRITE     = 3'd0,
        EV_SET_CLASS = 3'd1,
        EV_RESTART   = 3'd2,
        EV_GATHER    = 3'd3,
        EV_EXTEND    = 3'd4,
        EV_DONE      = 3'd5,
        EV_UNKNOWN   = 3'd6
    } t_event;

    localparam logic [GMODE_W-1:0] GMODE_NONE    = 2'd0;
    localparam logic [GMODE_W-1:0] GMODE_NONINCR = 2'd1;
    localparam logic [GMODE_W-1:0] GMODE_INCR    = 2'd2;

    typedef struct packed {
        t_phase                phase;
        logic [OFFSET_W-1:0]   cur_offset;
        logic [COUNT_W-1:0]    words_left;
        logic [MASK_W-1:0]     pend_mask;
        logic [GMODE_W-1:0]    gather_mode;
        logic [GCOUNT_W-1:0]   gather_count;
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]     event_kind;
        logic [OFFSET_W-1:0]   reg_offset;
        logic [WORD_W-1:0]     reg_value;
        logic [CLASS_W-1:0]    class_ident;
        logic [CMASK_W-1:0]    class_mask;
        logic [GMODE_W-1:0]    gather_mode;
        logic [GCOUNT_W-1:0]   gather_count;
        logic [SUBOP_W-1:0]    extend_subop;
    } t_result;

endpackage

/* hdl/csd_if.sv */
// ----------------------------------------------------------------------------
// csd_if
// Valid/ready channels of the decoder: command words in, events out.
// ----------------------------------------------------------------------------
interface csd_cmd_if
    import csd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] cmd_word;
    logic              last_word;

    modport source (output valid, output cmd_word, output last_word, input ready);
    modport sink   (input valid, input cmd_word, input last_word, output ready);
endinterface

interface csd_evt_if
    import csd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   event_kind;
    logic [OFFSET_W-1:0] reg_offset;
    logic [WORD_W-1:0]   reg_value;
    logic [CLASS_W-1:0]  class_ident;
    logic [CMASK_W-1:0]  class_mask;
    logic [GMODE_W-1:0]  gather_mode;
    logic [GCOUNT_W-1:0] gather_count;
    logic [SUBOP_W-1:0]  extend_subop;

    modport source (
        output valid, output event_kind, output reg_offset, output reg_value,
        output class_ident, output class_mask, output gather_mode,
        output gather_count, output extend_subop, input ready
    );
    modport sink (
        input valid, input event_kind, input reg_offset, input reg_value,
        input class_ident, input class_mask, input gather_mode,
        input gather_count, input extend_subop, output ready
    );
endinterface

/* hdl/csd_decode.sv */
// ----------------------------------------------------------------------------
// csd_decode
// Decodes one command word against the parser state: gives the next state
// and at most one event.
// ----------------------------------------------------------------------------
module csd_decode
    import csd_pkg::*;
(
    input  t_state            i_state,
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_last,
    output t_state            o_state,
    output logic              o_res_valid,
    output t_result           o_res
);

    logic [OPCODE_W-1:0] hdr_op;
    logic [OFFSET_W-1:0] hdr_off;
    logic [MASK_W-1:0]   low_bit;
    logic [MIDX_W-1:0]   low_idx;
    logic [MASK_W-1:0]   mask_left;
    logic [COUNT_W-1:0]  count_left;
    t_state              n_state;

    assign hdr_op  = i_word[31:28];
    assign hdr_off = i_word[27:16];

    // Lowest pending mask bit and its index.
    always_comb begin
        low_bit = i_state.pend_mask & (~i_state.pend_mask + MASK_W'(1));
        low_idx = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | MIDX_W'(i);
            end
        end
    end

    assign mask_left  = i_state.pend_mask & ~low_bit;
    assign count_left = i_state.words_left - COUNT_W'(1);

    always_comb begin
        n_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (i_state.phase)
            PH_MASKED: begin
                if (i_state.pend_mask != '0) begin
                    o_res_valid     = 1'b1;
                    o_res.event_kind = EV_WRITE;
                    o_res.reg_offset = i_state.cur_offset
                                       + OFFSET_W'(low_idx);
                    o_res.reg_value  = i_word;
                end
                n_state.pend_mask = mask_left;
                if (mask_left == '0) begin
                    n_state.phase = PH_HEADER;
                end
            end
            PH_INCR, PH_FIXED: begin
                o_res_valid      = 1'b1;
                o_res.event_kind = EV_WRITE;
                o_res.reg_offset = i_state.cur_offset;
                o_res.reg_value  = i_word;
                if (i_state.phase == PH_INCR) begin
                    n_state.cur_offset = i_state.cur_offset + OFFSET_W'(1);
                end
                n_state.words_left = count_left;
                if (count_left == '0) begin
                    n_state.phase = PH_HEADER;
                end
            end
            PH_GBASE: begin
                o_res_valid        = 1'b1;
                o_res.event_kind   = EV_GATHER;
                o_res.reg_offset   = i_state.cur_offset;
                o_res.reg_value    = i_word;
                o_res.gather_mode  = i_state.gather_mode;
                o_res.gather_count = i_state.gather_count;
                n_state.phase        = PH_HEADER;
                n_state.words_left   = '0;
                n_state.pend_mask    = '0;
                n_state.gather_mode  = GMODE_NONE;
                n_state.gather_count = '0;
            end
            default: begin
                n_state.phase = PH_HEADER;
                case (hdr_op)
                    OP_SET_CLASS: begin
                        n_state.cur_offset = hdr_off;
                        n_state.pend_mask  = MASK_W'(i_word[5:0]);
                        if (i_word[5:0] != '0) begin
                            n_state.phase = PH_MASKED;
                        end
                        o_res_valid       = 1'b1;
                        o_res.event_kind  = EV_SET_CLASS;
                        o_res.reg_offset  = hdr_off;
                        o_res.class_ident = i_word[15:6];
                        o_res.class_mask  = i_word[5:0];
                    end
                    OP_INCR, OP_NONINCR: begin
                        n_state.cur_offset = hdr_off;
                        n_state.words_left = i_word[15:0];
                        if (i_word[15:0] != '0) begin
                            n_state.phase = (hdr_op == OP_INCR) ? PH_INCR : PH_FIXED;
                        end
                    end
                    OP_MASK: begin
                        n_state.cur_offset = hdr_off;
                        n_state.pend_mask  = i_word[15:0];
                        if (i_word[15:0] != '0) begin
                            n_state.phase = PH_MASKED;
                        end
                    end
                    OP_IMM: begin
                        o_res_valid      = 1'b1;
                        o_res.event_kind = EV_WRITE;
                        o_res.reg_offset = hdr_off;
                        o_res.reg_value  = WORD_W'(i_word[15:0]);
                    end
                    OP_RESTART: begin
                        o_res_valid      = 1'b1;
                        o_res.event_kind = EV_RESTART;
                        o_res.reg_value  = {i_word[27:0], 4'b0000};
                    end
                    OP_GATHER: begin
                        n_state.cur_offset   = hdr_off;
                        n_state.gather_count = i_word[13:0];
                        if (i_word[15]) begin
                            n_state.gather_mode = i_word[14] ? GMODE_INCR : GMODE_NONINCR;
                        end else begin
                            n_state.gather_mode = GMODE_NONE;
                        end
                        n_state.phase = PH_GBASE;
                    end
                    OP_EXTEND: begin
                        o_res_valid        = 1'b1;
                        o_res.event_kind   = EV_EXTEND;
                        o_res.reg_value    = WORD_W'(i_word[23:0]);
                        o_res.extend_subop = i_word[27:24];
                    end
                    OP_DONE: begin
                        o_res_valid      = 1'b1;
                        o_res.event_kind = EV_DONE;
                    end
                    default: begin
                        o_res_valid      = 1'b1;
                        o_res.event_kind = EV_UNKNOWN;
                    end
                endcase
            end
        endcase

        // The final word of a buffer drops whatever data was still announced.
        if (i_last) begin
            n_state.phase        = PH_HEADER;
            n_state.words_left   = '0;
            n_state.pend_mask    = '0;
            n_state.gather_mode  = GMODE_NONE;
            n_state.gather_count = '0;
        end

        o_state = n_state;
    end

endmodule

/* hdl/command_stream_decoder.sv */
// ----------------------------------------------------------------------------
// command_stream_decoder
// Output: the event of an item is registered and offered in the cycle after the item is taken.
// Throughput: one command word per cycle; the event register frees as it is
// taken, so a stalled output holds the input only while that register is full.
// Reset: synchronous, active low; the parser expects a header, offset zero.
// ----------------------------------------------------------------------------
module command_stream_decoder
    import csd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    csd_cmd_if.sink          i_cmd,
    csd_evt_if.source        o_evt
);

    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_res_valid;
    logic    n_res_valid;
    logic    cmd_acc;

    assign i_cmd.ready = !r_res_valid || o_evt.ready;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    csd_decode u_decode (
        .i_state     (r_state),
        .i_word      (i_cmd.cmd_word),
        .i_last      (i_cmd.last_word),
        .o_state     (n_state),
        .o_res_valid (n_res_valid),
        .o_res       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: PH_HEADER, default: '0};
            r_res_valid <= 1'b0;
        end else if (cmd_acc) begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end else if (o_evt.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_res <= n_res;
        end
    end

    assign o_evt.valid        = r_res_valid;
    assign o_evt.event_kind   = r_res.event_kind;
    assign o_evt.reg_offset   = r_res.reg_offset;
    assign o_evt.reg_value    = r_res.reg_value;
    assign o_evt.class_ident  = r_res.class_ident;
    assign o_evt.class_mask   = r_res.class_mask;
    assign o_evt.gather_mode  = r_res.gather_mode;
    assign o_evt.gather_count = r_res.gather_count;
    assign o_evt.extend_subop = r_res.extend_subop;

`ifndef SYNTHESIS
    a_masked_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_MASKED |-> r_state.pend_mask != '0)
        else $error("masked phase with an empty mask");

    a_counted_has_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_INCR || r_state.phase == PH_FIXED)
        |-> r_state.words_left != '0)
        else $error("counted phase with no words left");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc && i_cmd.last_word |=> r_state.phase == PH_HEADER
        && r_state.words_left == '0 && r_state.pend_mask == '0)
        else $error("last word left data pending");

    a_gather_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc && r_state.phase == PH_GBASE
        |=> r_state.phase == PH_HEADER && r_res_valid
        && r_res.event_kind == EV_GATHER)
        else $error("gather base did not yield a gather event");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_res_valid |-> i_cmd.ready)
        else $error("input stalled with an empty event register");
`endif

endmodule

/* tb/sv/command_stream_decoder_tb.sv */
// ----------------------------------------------------------------------------
// command_stream_decoder_tb
// Drives command words into the decoder and checks every event it emits.
// A scoreboard tracks the parser state, predicts the event of each accepted
// item and compares it, field by field, with what the block produces.
// ----------------------------------------------------------------------------
module command_stream_decoder_tb;
    import csd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ITEM_GOAL   = 2000;
    localparam int unsigned CALM_AFTER  = 1750;

    // Opcodes that the decoder does not implement span this range.
    localparam logic [OPCODE_W-1:0] OP_UNKNOWN_LO = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_UNKNOWN_HI = 4'd13;

    class decoder_scoreboard;
        t_phase              phase;
        logic [OFFSET_W-1:0] cur_offset;
        logic [COUNT_W-1:0]  words_left;
        logic [MASK_W-1:0]   pend_mask;
        logic [GMODE_W-1:0]  held_mode;
        logic [GCOUNT_W-1:0] held_count;
        t_result             expected_events[$];
        int unsigned         fail_count;
        int unsigned         checked_count;

        function new();
            fail_count    = 0;
            checked_count = 0;
            reset_parser();
        endfunction

        function void drop_pending();
            phase      = PH_HEADER;
            words_left = '0;
            pend_mask  = '0;
            held_mode  = GMODE_NONE;
            held_count = '0;
        endfunction

        function void reset_parser();
            drop_pending();
            cur_offset = '0;
        endfunction

        // Advance the parser by one accepted word and queue the event it causes.
        function void note_cmd(logic [WORD_W-1:0] w, logic last);
            t_result             ev;
            bit                  emit;
            int                  bit_idx;
            logic [OFFSET_W-1:0] hdr_off;

            ev      = '0;
            emit    = 1'b0;
            hdr_off = w[27:16];
            case (phase)
                PH_MASKED: begin
                    for (bit_idx = 0; bit_idx < MASK_W && !pend_mask[bit_idx]; bit_idx++);
                    if (bit_idx < MASK_W) begin
                        ev.event_kind = EV_WRITE;
                        ev.reg_offset = cur_offset + bit_idx[OFFSET_W-1:0];
                        ev.reg_value  = w;
                        pend_mask[bit_idx] = 1'b0;
                        emit = 1'b1;
                    end
                    if (pend_mask == '0)
                        phase = PH_HEADER;
                end
                PH_INCR, PH_FIXED: begin
                    ev.event_kind = EV_WRITE;
                    ev.reg_offset = cur_offset;
                    ev.reg_value  = w;
                    emit = 1'b1;
                    if (phase == PH_INCR)
                        cur_offset = cur_offset + 1'b1;
                    words_left = words_left - 1'b1;
                    if (words_left == '0)
                        phase = PH_HEADER;
                end
                PH_GBASE: begin
                    ev.event_kind   = EV_GATHER;
                    ev.reg_offset   = cur_offset;
                    ev.reg_value    = w;
                    ev.gather_mode  = held_mode;
                    ev.gather_count = held_count;
                    emit = 1'b1;
                    drop_pending();
                end
                default: begin
                    phase = PH_HEADER;
                    emit  = 1'b1;
                    case (w[31:28])
                        OP_SET_CLASS: begin
                            cur_offset     = hdr_off;
                            pend_mask      = {10'd0, w[5:0]};
                            phase          = (w[5:0] != '0) ? PH_MASKED : PH_HEADER;
                            ev.event_kind  = EV_SET_CLASS;
                            ev.reg_offset  = hdr_off;
                            ev.class_ident = w[15:6];
                            ev.class_mask  = w[5:0];
                        end
                        OP_INCR, OP_NONINCR: begin
                            cur_offset = hdr_off;
                            words_left = w[15:0];
                            if (w[15:0] == '0)
                                phase = PH_HEADER;
                            else
                                phase = (w[31:28] == OP_INCR) ? PH_INCR : PH_FIXED;
                            emit = 1'b0;
                        end
                        OP_MASK: begin
                            cur_offset = hdr_off;
                            pend_mask  = w[15:0];
                            phase      = (w[15:0] != '0) ? PH_MASKED : PH_HEADER;
                            emit       = 1'b0;
                        end
                        OP_IMM: begin
                            ev.event_kind = EV_WRITE;
                            ev.reg_offset = hdr_off;
                            ev.reg_value  = {16'd0, w[15:0]};
                        end
                        OP_RESTART: begin
                            ev.event_kind = EV_RESTART;
                            ev.reg_value  = {w[27:0], 4'd0};
                        end
                        OP_GATHER: begin
                            cur_offset = hdr_off;
                            held_count = w[13:0];
                            if (w[15])
                                held_mode = w[14] ? GMODE_INCR : GMODE_NONINCR;
                            else
                                held_mode = GMODE_NONE;
                            phase = PH_GBASE;
                            emit  = 1'b0;
                        end
                        OP_EXTEND: begin
                            ev.event_kind   = EV_EXTEND;
                            ev.reg_value    = {8'd0, w[23:0]};
                            ev.extend_subop = w[27:24];
                        end
                        OP_DONE: begin
                            ev.event_kind = EV_DONE;
                        end
                        default: begin
                            ev.event_kind = EV_UNKNOWN;
                        end
                    endcase
                end
            endcase
            if (last)
                drop_pending();
            if (emit)
                expected_events.push_back(ev);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            fail_count++;
        endtask

        task compare_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("event %0d %s: got 0x%0h, want 0x%0h",
                                          checked_count, name, got, want));
        endtask

        task check_event(t_result got);
            t_result want;

            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("event with no expectation, kind %0d value 0x%0h",
                                          got.event_kind, got.reg_value));
            end else begin
                want = expected_events.pop_front();
                compare_field("event_kind", WORD_W'(got.event_kind),
                              WORD_W'(want.event_kind));
                compare_field("reg_offset", WORD_W'(got.reg_offset),
                              WORD_W'(want.reg_offset));
                compare_field("reg_value", got.reg_value, want.reg_value);
                compare_field("class_ident", WORD_W'(got.class_ident),
                              WORD_W'(want.class_ident));
                compare_field("class_mask", WORD_W'(got.class_mask),
                              WORD_W'(want.class_mask));
                compare_field("gather_mode", WORD_W'(got.gather_mode),
                              WORD_W'(want.gather_mode));
                compare_field("gather_count", WORD_W'(got.gather_count),
                              WORD_W'(want.gather_count));
                compare_field("extend_subop", WORD_W'(got.extend_subop),
                              WORD_W'(want.extend_subop));
            end
            checked_count++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    csd_cmd_if cmd_ch ();
    csd_evt_if evt_ch ();

    command_stream_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_evt   (evt_ch)
    );

    decoder_scoreboard sb = new();

    bit          tx_idle_on;
    bit          rx_idle_on;
    int unsigned items_sent;
    int unsigned stall_left;
    int unsigned cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Offer one word, with an occasional gap in front, and wait until it is taken.
    task automatic send_cmd(input logic [WORD_W-1:0] w, input logic last);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.cmd_word  <= w;
        cmd_ch.last_word <= last;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_cmd(w, last);
        items_sent++;
    endtask

    function automatic logic [WORD_W-1:0] data_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // One header with its data words; some are cut short, some end the buffer.
    task automatic run_sequence();
        logic [OFFSET_W-1:0] off;
        logic [15:0]         field;
        logic [WORD_W-1:0]   hdr;
        int                  n_data;
        int                  n_send;
        bit                  broken;
        bit                  last_hdr;
        int                  k;

        off      = OFFSET_W'($urandom_range(0, 4095));
        field    = 16'($urandom);
        n_data   = 0;
        last_hdr = 1'b0;
        if ($urandom_range(0, 3) == 0)
            off = 12'hfff - OFFSET_W'($urandom_range(0, 15));
        case ($urandom_range(0, 11))
            0, 1: begin
                hdr    = {OP_SET_CLASS, off, field[15:6], field[5:0]};
                n_data = $countones(field[5:0]);
            end
            2, 3: begin
                if ($urandom_range(0, 15) != 0)
                    field = 16'($urandom_range(0, 8));
                hdr    = {($urandom_range(0, 1) ? OP_INCR : OP_NONINCR), off, field};
                n_data = int'(field);
            end
            4: begin
                if ($urandom_range(0, 1))
                    field = field & 16'($urandom);
                hdr    = {OP_MASK, off, field};
                n_data = $countones(field);
            end
            5: hdr = {OP_IMM, off, field};
            6: hdr = {OP_RESTART, 28'($urandom)};
            7: begin
                hdr    = {OP_GATHER, off, field};
                n_data = 1;
            end
            8: hdr = {OP_EXTEND, 28'($urandom)};
            9: hdr = {OP_DONE, 28'($urandom)};
            10: hdr = {4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI)), 28'($urandom)};
            default: begin
                // Raw noise; a long count from it is ended right away.
                hdr      = $urandom;
                last_hdr = (hdr[31:28] == OP_INCR || hdr[31:28] == OP_NONINCR) ||
                           ($urandom_range(0, 3) == 0);
            end
        endcase
        broken = (n_data > 16) || ($urandom_range(0, 11) == 0);
        n_send = n_data;
        if (broken && n_data > 0)
            n_send = $urandom_range(0, (n_data > 8) ? 8 : n_data - 1);
        if (broken && n_send == 0)
            last_hdr = 1'b1;
        send_cmd(hdr, last_hdr && !(broken && n_send > 0));
        for (k = 0; k < n_send; k++)
            send_cmd(data_word(), (k == n_send - 1) && (broken || $urandom_range(0, 7) == 0));
    endtask

    initial begin
        cmd_ch.valid     <= 1'b0;
        cmd_ch.cmd_word  <= '0;
        cmd_ch.last_word <= 1'b0;
        i_rst_n          <= 1'b0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        items_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every opcode, empty announcements,
        // offset wrap and an abandoned buffer tail.
        send_cmd({OP_SET_CLASS, 12'hffe, 10'h3ff, 6'h21}, 1'b0);
        send_cmd(32'hffff_ffff, 1'b0);
        send_cmd(32'h0000_0000, 1'b0);
        send_cmd({OP_SET_CLASS, 12'h000, 10'h000, 6'h00}, 1'b0);
        send_cmd({OP_INCR, 12'hfff, 16'd2}, 1'b0);
        send_cmd(32'h1234_5678, 1'b0);
        send_cmd(32'h9abc_def0, 1'b0);
        send_cmd({OP_INCR, 12'h555, 16'd0}, 1'b0);
        send_cmd({OP_NONINCR, 12'h123, 16'd2}, 1'b0);
        send_cmd(32'h0f0f_0f0f, 1'b0);
        send_cmd(32'hf0f0_f0f0, 1'b0);
        send_cmd({OP_MASK, 12'hff8, 16'h8001}, 1'b0);
        send_cmd(32'haaaa_5555, 1'b0);
        send_cmd(32'h5555_aaaa, 1'b0);
        send_cmd({OP_MASK, 12'h0aa, 16'h0000}, 1'b0);
        send_cmd({OP_IMM, 12'habc, 16'hffff}, 1'b0);
        send_cmd({OP_RESTART, 28'hfff_ffff}, 1'b0);
        send_cmd({OP_GATHER, 12'h010, 16'hffff}, 1'b0);
        send_cmd(32'hdead_beef, 1'b0);
        send_cmd({OP_GATHER, 12'hfff, 16'h8000}, 1'b0);
        send_cmd(32'h0000_0001, 1'b0);
        send_cmd({OP_GATHER, 12'h001, 16'h4001}, 1'b0);
        send_cmd(32'h8000_0000, 1'b0);
        send_cmd({OP_EXTEND, 4'hf, 24'hff_ffff}, 1'b0);
        send_cmd({OP_DONE, 28'h000_0000}, 1'b0);
        send_cmd({OP_UNKNOWN_LO, 28'hfff_ffff}, 1'b0);
        send_cmd({OP_UNKNOWN_HI, 28'h000_0000}, 1'b0);
        send_cmd({OP_INCR, 12'h100, 16'd3}, 1'b0);
        send_cmd(32'hcafe_f00d, 1'b1);
        send_cmd({OP_GATHER, 12'h200, 16'hc005}, 1'b1);
        send_cmd({OP_DONE, 28'hfff_ffff}, 1'b0);

        while (items_sent < ITEM_GOAL) begin
            if (items_sent >= CALM_AFTER) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else begin
                if ($urandom_range(0, 24) == 0)
                    tx_idle_on = !tx_idle_on;
                if ($urandom_range(0, 24) == 0)
                    rx_idle_on = !rx_idle_on;
            end
            run_sequence();
        end
        cmd_ch.valid <= 1'b0;

        while (sb.expected_events.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Event side: check each taken event, then pick ready for the next cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (evt_ch.valid && evt_ch.ready)
                sb.check_event({evt_ch.event_kind, evt_ch.reg_offset, evt_ch.reg_value,
                                evt_ch.class_ident, evt_ch.class_mask, evt_ch.gather_mode,
                                evt_ch.gather_count, evt_ch.extend_subop});
            if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                evt_ch.ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                stall_left   <= $urandom_range(0, 7);
                evt_ch.ready <= 1'b0;
            end else begin
                evt_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
